### hdl/mbsm_pkg.sv
// Shared types and constants for the masked byte signature matcher.
// Holds the register map, the configuration bundle and the default sizes.
// No dependencies.
package mbsm_pkg;

  // Default sizes handed to the top level parameters
  localparam int MAX_BYTES_DEF   = 32;
  localparam int OFFSET_BITS_DEF = 32;

  // Signature storage is fixed by the register map
  localparam int SIG_BYTES = 32;
  localparam int LEN_W     = 6;
  localparam int ADDR_OUT_W = 32;

  // APB port geometry: 64-bit registers at byte address 8*i
  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 3;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_PAT0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAT1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAT2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PAT3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CARE = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LEN  = 3'd5;

  // Configuration bundle from the register file to the compare logic
  typedef struct packed {
    logic [SIG_BYTES-1:0][7:0] sig;
    logic [SIG_BYTES-1:0]      care;
    logic [LEN_W-1:0]          len;
  } cfg_t;

endpackage

### hdl/mbsm_regs.sv
// APB register file of the signature matcher: signature bytes, care mask
// and signature length. Depends on mbsm_pkg.
module mbsm_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mbsm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [mbsm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mbsm_pkg::APB_DATA_W-1:0]  prdata,
  output mbsm_pkg::cfg_t                   cfg
);

  logic [3:0][63:0]                 pat;
  logic [31:0]                      care;
  logic [mbsm_pkg::LEN_W-1:0]       len;
  logic [mbsm_pkg::REG_IDX_W-1:0]   idx;
  logic                             wr_en;

  assign idx   = paddr[mbsm_pkg::APB_ADDR_W-1:3];
  assign wr_en = psel && penable && pwrite;

  // Register writes; indexes past the map are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      pat  <= '0;
      care <= '0;
      len  <= '0;
    end else if (wr_en) begin
      case (idx)
        mbsm_pkg::REG_PAT0: pat[0] <= pwdata;
        mbsm_pkg::REG_PAT1: pat[1] <= pwdata;
        mbsm_pkg::REG_PAT2: pat[2] <= pwdata;
        mbsm_pkg::REG_PAT3: pat[3] <= pwdata;
        mbsm_pkg::REG_CARE: care   <= pwdata[31:0];
        mbsm_pkg::REG_LEN:  len    <= pwdata[mbsm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      mbsm_pkg::REG_PAT0: prdata = pat[0];
      mbsm_pkg::REG_PAT1: prdata = pat[1];
      mbsm_pkg::REG_PAT2: prdata = pat[2];
      mbsm_pkg::REG_PAT3: prdata = pat[3];
      mbsm_pkg::REG_CARE: prdata = {32'd0, care};
      mbsm_pkg::REG_LEN:  prdata = {{(mbsm_pkg::APB_DATA_W - mbsm_pkg::LEN_W){1'b0}}, len};
      default:            prdata = '0;
    endcase
  end

  // Byte 8*r+k sits in bits 8k+7..8k of register r
  assign cfg.sig  = pat;
  assign cfg.care = care;
  assign cfg.len  = len;

endmodule

### hdl/mbsm_match.sv
// Masked window compare: checks the window ending at the current byte
// against the signature, one comparator per signature position.
// Depends on mbsm_pkg.
module mbsm_match #(
  parameter int MAX_BYTES = mbsm_pkg::MAX_BYTES_DEF
) (
  input  mbsm_pkg::cfg_t                 cfg,
  input  logic [MAX_BYTES-1:0][7:0]      win,     // [0] current, [k] k bytes back
  output logic [mbsm_pkg::LEN_W-1:0]     len_eff,
  output logic                           hit
);

  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  logic [MAX_BYTES-1:0] pos_ok;

  // Lengths above the window size act as the window size
  assign len_eff = (cfg.len > mbsm_pkg::LEN_W'(MAX_BYTES)) ?
                   mbsm_pkg::LEN_W'(MAX_BYTES) : cfg.len;

  // Signature byte j lines up with the byte len-1-j places back
  for (genvar j = 0; j < MAX_BYTES; j++) begin : g_pos
    logic [mbsm_pkg::LEN_W-1:0] back;
    assign back = len_eff - mbsm_pkg::LEN_W'(j + 1);
    assign pos_ok[j] = (mbsm_pkg::LEN_W'(j) >= len_eff) || !cfg.care[j] ||
                       (win[back[IDX_W-1:0]] == cfg.sig[j]);
  end

  assign hit = (len_eff != '0) && (&pos_ok);

endmodule

### hdl/masked_byte_signature_matcher_core.sv
// Top level of the masked byte signature matcher: input register, byte
// history, byte count, match decision and result register.
// Depends on mbsm_pkg, mbsm_regs and mbsm_match.
//
// Usage:
//   Bytes of a buffer enter on the s_ stream, one beat per byte, s_tlast on
//   the final byte. Each buffer yields one result beat on the m_ stream:
//   m_tuser = 1 with m_tdata = start offset of the first matching window, or
//   m_tuser = 0 with m_tdata = 0 on the last byte when nothing matched.
//   Bytes after a match give no beat until the buffer ends.
//   A result passes through the input register and then the result register;
//   a byte waits there while the result register holds an unread result.
//   Throughput: one byte per cycle while results drain; the compare of all
//   signature positions runs in parallel in the logic between the registers.
//   When m_tready is low and a result waits, the input register still
//   fills, so one more byte is taken before s_tready drops.
//   Reset clears history, byte count, match flag, both valid flags and all
//   configuration registers. Configure over APB while the stream is idle.
module masked_byte_signature_matcher_core #(
  parameter int MAX_BYTES   = mbsm_pkg::MAX_BYTES_DEF,
  parameter int OFFSET_BITS = mbsm_pkg::OFFSET_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mbsm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [mbsm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mbsm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  // byte stream in
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] data_byte
  input  logic                             s_tlast,   // last_byte
  // result stream out
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [31:0]                      m_tdata,   // [31:0] match_address
  output logic                             m_tuser    // found
);

  localparam int SUM_W = (OFFSET_BITS < 64) ? OFFSET_BITS + 1 : 64;

  mbsm_pkg::cfg_t                 cfg;
  logic [MAX_BYTES-1:0][7:0]      win;
  logic [mbsm_pkg::LEN_W-1:0]     len_eff;
  logic                           hit;

  logic                           s1_valid;
  logic [7:0]                     s1_byte;
  logic                           s1_last;
  logic [OFFSET_BITS-1:0]         byte_count;
  logic                           reported;
  logic                           out_valid;
  logic                           out_found;
  logic [31:0]                    out_addr;

  logic                           in_beat;
  logic                           advance;
  logic [SUM_W-1:0]               count_inc;
  logic [SUM_W-1:0]               start_off;
  logic                           win_inside;
  logic                           emit_hit;
  logic                           emit_miss;

  assign pready = 1'b1;

  mbsm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Byte history behind the current byte; the oldest byte drops off the top
  if (MAX_BYTES > 1) begin : g_hist
    localparam int HIST_W = (MAX_BYTES - 1) * 8;
    logic [MAX_BYTES-2:0][7:0] hist;
    always_ff @(posedge clk) begin
      if (rst) begin
        hist <= '0;
      end else if (advance) begin
        hist <= HIST_W'({hist, s1_byte});
      end
    end
    assign win = {hist, s1_byte};
  end else begin : g_nohist
    assign win = s1_byte;
  end

  mbsm_match #(
    .MAX_BYTES (MAX_BYTES)
  ) u_match (
    .cfg     (cfg),
    .win     (win),
    .len_eff (len_eff),
    .hit     (hit)
  );

  // Handshake: stage 1 moves on when the result register is free or drains
  assign in_beat  = s_tvalid && s_tready;
  assign advance  = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || advance;

  // Window must lie within the current buffer
  assign count_inc  = SUM_W'(byte_count) + SUM_W'(1);
  assign win_inside = count_inc >= SUM_W'(len_eff);
  assign start_off  = count_inc - SUM_W'(len_eff);

  assign emit_hit  = !reported && hit && win_inside;
  assign emit_miss = !reported && !emit_hit && s1_last;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_beat) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_byte <= s_tdata;
      s1_last <= s_tlast;
    end
  end

  // Buffer state: saturating byte count and reported flag
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      reported   <= 1'b0;
    end else if (advance) begin
      if (s1_last) begin
        byte_count <= '0;
        reported   <= 1'b0;
      end else begin
        if (byte_count != '1) begin
          byte_count <= byte_count + OFFSET_BITS'(1);
        end
        reported <= reported || emit_hit;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit_hit || emit_miss;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_found <= emit_hit;
      out_addr  <= emit_hit ? 32'(start_off) : 32'd0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_found;
  assign m_tdata  = out_addr;

endmodule

### verif/masked_byte_signature_matcher_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for masked_byte_signature_matcher_core: byte stream
// in, match results out. It checks every result beat against a local scan model.
// Depends on mbsm_pkg and the core RTL.
module masked_byte_signature_matcher_core_test;

  localparam int SCAN_BYTES   = mbsm_pkg::MAX_BYTES_DEF;
  localparam int HIST_DEPTH   = SCAN_BYTES - 1;
  localparam int IDLE_PCT     = 28;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 4;   // two register stages plus margin
  localparam int PHASE_BYTES  = 68;
  localparam int PHASES       = 8;
  localparam logic [mbsm_pkg::REG_IDX_W-1:0] REG_SPARE = 3'd6;   // first unmapped index

  typedef struct packed {
    logic        found;
    logic [31:0] addr;
  } match_result_t;

  // directed row: a register write, or one byte with an optional typed result
  typedef struct packed {
    logic                           cfg_row;
    logic [mbsm_pkg::REG_IDX_W-1:0] reg_idx;
    logic [63:0]                    reg_value;
    logic [7:0]                     data;
    logic                           last;
    logic                           typed;
    logic                           exp_beat;
    logic                           exp_found;
    logic [31:0]                    exp_addr;
  } stim_row_t;

  logic                            clk;
  logic                            rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [mbsm_pkg::APB_ADDR_W-1:0] paddr;
  logic [mbsm_pkg::APB_DATA_W-1:0] pwdata;
  logic [mbsm_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [7:0]                      s_tdata;   // [7:0] data_byte
  logic                            s_tlast;   // last_byte
  logic                            m_tvalid;
  logic                            m_tready;
  logic [31:0]                     m_tdata;   // [31:0] match_address
  logic                            m_tuser;   // found

  masked_byte_signature_matcher_core DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // scan model state
  logic [63:0] sig_words [4];
  logic [31:0] care_bits;
  logic [5:0]  sig_len;
  logic [7:0]  recent [HIST_DEPTH];   // [0] is the most recent byte
  logic [31:0] run_count;
  logic        reported;

  match_result_t expected_matches[$];
  match_result_t oldest_match;
  logic [7:0]    buffer_bytes[$];
  int            failures = 0;
  int            stuck_cycles = 0;
  logic          quiet;
  logic          hold_request;

  stim_row_t directed_rows [24] = '{
    // reset config: length zero, every buffer ends without a match
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0},
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'h80, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
    // signature DE AD BE EF, all bytes cared, plus a write to an unmapped index
    '{1'b1, mbsm_pkg::REG_PAT0, 64'hFF00_0000_EFBE_ADDE, 8'h0, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
    '{1'b1, mbsm_pkg::REG_CARE, 64'h0000_0000_FFFF_FFFF, 8'h0, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
    '{1'b1, mbsm_pkg::REG_LEN,  64'd4,                   8'h0, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
    '{1'b1, REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h0, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
    // match at offset one, then silence until the buffer ends
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'h11, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'hDE, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'hAD, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'hBE, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'hEF, 1'b0, 1'b1, 1'b1, 1'b1, 32'h1},
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'h22, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0},
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'h33, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0},
    // window would reach back into the previous buffer
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'hDE, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'hAD, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0},
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'hBE, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0},
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'hEF, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
    // match on the last byte: no end-of-buffer beat follows
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'hDE, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'hAD, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'hBE, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0},
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'hEF, 1'b1, 1'b1, 1'b1, 1'b1, 32'h0},
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
    '{1'b0, mbsm_pkg::REG_PAT0, 64'h0, 8'h7F, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0}
  };

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [7:0] sig_byte(input int j);
    return sig_words[j >> 3][(j % 8) * 8 +: 8];
  endfunction

  function automatic int active_len();
    return (sig_len > SCAN_BYTES) ? SCAN_BYTES : int'(sig_len);
  endfunction

  // Scan one byte: decide the result for this byte, then advance history and count.
  task automatic scan_byte_for_match(input logic [7:0] b, input logic last,
                                     output logic beat, output match_result_t res);
    int          len;
    int          back;
    logic        hit;
    logic [7:0]  wb;
    len  = active_len();
    beat = 1'b0;
    res  = '0;
    if (!reported) begin
      hit = (len != 0) && (33'(run_count) + 33'd1 >= 33'(len));
      for (int j = 0; j < len; j++) begin
        back = len - 1 - j;
        if (back == 0) wb = b;
        else wb = recent[back - 1];
        if (care_bits[j] && wb != sig_byte(j)) hit = 1'b0;
      end
      if (hit) begin
        beat = 1'b1;
        res.found = 1'b1;
        res.addr = run_count + 32'd1 - 32'(len);
        reported = 1'b1;
      end else if (last) begin
        beat = 1'b1;
      end
    end
    for (int k = HIST_DEPTH - 1; k > 0; k--) recent[k] = recent[k - 1];
    recent[0] = b;
    if (last) begin
      run_count = '0;
      reported = 1'b0;
    end else if (run_count != '1) begin
      run_count++;
    end
  endtask

  // Offer one byte, with random idle cycles ahead of it, until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!(s_tvalid && s_tready)) @(posedge clk);
  endtask

  task automatic send_and_predict(input logic [7:0] b, input logic last);
    logic          beat;
    match_result_t res;
    send_byte(b, last);
    scan_byte_for_match(b, last, beat, res);
    if (beat) expected_matches.push_back(res);
  endtask

  // Stop offering, wait for every pending result, then let the pipe settle.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mbsm_pkg::REG_IDX_W-1:0] idx,
                           input logic [63:0] value);
    wait_drained();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      mbsm_pkg::REG_PAT0: sig_words[0] = value;
      mbsm_pkg::REG_PAT1: sig_words[1] = value;
      mbsm_pkg::REG_PAT2: sig_words[2] = value;
      mbsm_pkg::REG_PAT3: sig_words[3] = value;
      mbsm_pkg::REG_CARE: care_bits = value[31:0];
      mbsm_pkg::REG_LEN:  sig_len = value[mbsm_pkg::LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // One buffer: mostly a planted signature with random wildcard bytes,
  // sometimes with one signature byte corrupted, sometimes plain noise.
  task automatic build_buffer();
    int len;
    int kind;
    int pre;
    int post;
    int pos;
    len = active_len();
    kind = $urandom_range(0, 99);
    buffer_bytes.delete();
    pre = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    repeat (pre) buffer_bytes.push_back(8'($urandom));
    if (kind < 75 && len > 0) begin
      for (int j = 0; j < len; j++)
        buffer_bytes.push_back(care_bits[j] ? sig_byte(j) : 8'($urandom));
      if (kind >= 60) begin
        pos = pre + $urandom_range(0, len - 1);
        buffer_bytes[pos] = buffer_bytes[pos] ^ 8'($urandom_range(1, 255));
      end
    end
    post = $urandom_range(0, 6);
    repeat (post) buffer_bytes.push_back(8'($urandom));
    if (buffer_bytes.size() == 0) buffer_bytes.push_back(8'($urandom));
  endtask

  // Result side: random back-pressure, plus one long hold on request.
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) begin
          m_tready <= 1'b0;
          @(negedge clk);
        end
      end
      m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_matches.size() == 0) begin
        $error("result beat with nothing expected: found=%0b match_address=%0h",
               m_tuser, m_tdata);
        failures++;
      end else begin
        oldest_match = expected_matches.pop_front();
        if (m_tuser !== oldest_match.found) begin
          $error("found: expected %0b, got %0b", oldest_match.found, m_tuser);
          failures++;
        end
        if (m_tdata !== oldest_match.addr) begin
          $error("match_address: expected %0h, got %0h", oldest_match.addr, m_tdata);
          failures++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on any port
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    logic          beat;
    match_result_t res;
    logic [63:0]   pats [4];
    logic [31:0]   care;
    logic [63:0]   len_word;
    int            sent;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    quiet = 1'b0;
    hold_request = 1'b0;
    for (int r = 0; r < 4; r++) sig_words[r] = '0;
    care_bits = '0;
    sig_len = '0;
    for (int k = 0; k < HIST_DEPTH; k++) recent[k] = '0;
    run_count = '0;
    reported = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_row) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_value);
      end else begin
        send_byte(directed_rows[i].data, directed_rows[i].last);
        scan_byte_for_match(directed_rows[i].data, directed_rows[i].last, beat, res);
        if (directed_rows[i].typed) begin
          beat = directed_rows[i].exp_beat;
          res.found = directed_rows[i].exp_found;
          res.addr = directed_rows[i].exp_addr;
        end
        if (beat) expected_matches.push_back(res);
      end
    end

    // random phases, each with its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      for (int r = 0; r < 4; r++) pats[r] = {$urandom, $urandom};
      care = $urandom;
      len_word = {$urandom, $urandom};
      len_word[mbsm_pkg::LEN_W-1:0] = 6'($urandom_range(0, 63));
      case (phase)
        0: begin
          care = '1;
          len_word = 64'd32;
        end
        1: begin
          care = '0;
          len_word = 64'd1;
        end
        2: len_word = 64'd0;
        3: len_word = 64'd63;   // beyond the window, acts as full width
        4: begin
          for (int r = 0; r < 4; r++) pats[r] = '0;
          len_word = 64'($urandom_range(2, 8));
        end
        5: begin
          for (int r = 0; r < 4; r++) pats[r] = '1;
          len_word = 64'($urandom_range(1, 31));
        end
        default: ;
      endcase
      write_reg(mbsm_pkg::REG_PAT0, pats[0]);
      write_reg(mbsm_pkg::REG_PAT1, pats[1]);
      write_reg(mbsm_pkg::REG_PAT2, pats[2]);
      write_reg(mbsm_pkg::REG_PAT3, pats[3]);
      write_reg(mbsm_pkg::REG_CARE, {$urandom, care});
      write_reg(mbsm_pkg::REG_LEN, len_word);
      write_reg(REG_SPARE + 3'($urandom_range(0, 1)), {$urandom, $urandom});

      quiet = (phase == 4);
      if (phase == 1) hold_request = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_buffer();
        foreach (buffer_bytes[i])
          send_and_predict(buffer_bytes[i], i == buffer_bytes.size() - 1);
        sent += buffer_bytes.size();
        // in phase 5, after its first buffer, the sender pauses until every result is back
        if (phase == 5 && sent == buffer_bytes.size()) wait_drained();
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_matches.size() != 0) begin
      $error("%0d expected results never arrived", expected_matches.size());
    end
    if (failures == 0 && expected_matches.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
